/* rtl/core/file_directory_sector_allocator_defines.svh */
// Assertion macros for the file directory sector allocator.
// No dependencies; included by the top level only.
`ifndef FILE_DIRECTORY_SECTOR_ALLOCATOR_DEFINES_SVH
`define FILE_DIRECTORY_SECTOR_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FDSA_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FDSA_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fdsa_pkg.sv */
// Shared types and constants of the file directory sector allocator.
// No dependencies; used by fdsa_ctrl, fdsa_dpath and the top level.
package fdsa_pkg;

    localparam int DIR_ENTRIES  = 16;
    localparam int ENTRY_BYTES  = 32;
    localparam int NAME_BYTES   = 6;
    localparam int MAP_ENTRIES  = 256;
    localparam int SECTOR_LIMIT = 26;
    localparam int SLOT_COUNT   = (ENTRY_BYTES - NAME_BYTES) < SECTOR_LIMIT ?
                                  (ENTRY_BYTES - NAME_BYTES) : SECTOR_LIMIT;
    localparam int DIR_BYTES    = DIR_ENTRIES * ENTRY_BYTES;
    localparam int DIR_BASE     = 256;

    localparam int E_W    = $clog2(DIR_ENTRIES);
    localparam int OFF_W  = $clog2(ENTRY_BYTES);
    localparam int DIR_AW = $clog2(DIR_BYTES);
    localparam int MAP_AW = $clog2(MAP_ENTRIES);
    localparam int SLOT_W = MAP_AW + 1;
    localparam int GOT_W  = $clog2(SLOT_COUNT + 1);

    localparam logic [7:0] FREE_FULL = 8'hFF;

    // request kinds
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CREATE = 2'd3
    } t_action;

    // result codes
    typedef enum logic [2:0] {
        ST_SECTOR    = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DIR_FULL  = 3'd3,
        ST_NO_SPACE  = 3'd4,
        ST_READ      = 3'd5,
        ST_LOADED    = 3'd6
    } t_status;

    // read address source
    typedef enum logic [2:0] {
        RD_USER = 3'd0,
        RD_NAME = 3'd1,
        RD_SECT = 3'd2,
        RD_HEAD = 3'd3,
        RD_MAP  = 3'd4
    } t_rd_sel;

    // sector field source of a result
    typedef enum logic [1:0] {
        SEC_NONE = 2'd0,
        SEC_PEND = 2'd1,
        SEC_PICK = 2'd2
    } t_sec_sel;

    typedef struct packed {
        logic     capture;
        logic     clr_step;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_load;
        logic     wr_name;
        logic     wr_commit;
        logic     e_clr;
        logic     e_inc;
        logic     i_clr;
        logic     i_inc;
        logic     slot_init;
        logic     slot_inc;
        logic     got_clr;
        logic     pick;
        logic     pend_load;
        logic     out_load;
        t_status  out_status;
        t_sec_sel out_sec;
        logic     out_last;
    } t_cmd;

    typedef struct packed {
        logic    clr_done;
        t_action action;
        logic    name_eq;
        logic    rd_zero;
        logic    rd_ff;
        logic    i_at_len;
        logic    i_sect_last;
        logic    i_name_last;
        logic    i_got_last;
        logic    e_last;
        logic    slot_end;
        logic    got_eq;
        logic    got_zero;
        logic    count_big;
        logic    out_free;
    } t_sts;

endpackage

/* rtl/core/fdsa_dpath.sv */
// Datapath: request registers, directory and map memories, scan counters,
// picked-sector list and result register. Depends on fdsa_pkg.
module fdsa_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fdsa_pkg::t_cmd        i_cmd,
    output fdsa_pkg::t_sts        o_sts,
    input  logic [1:0]            i_action,
    input  logic [9:0]            i_address,
    input  logic [7:0]            i_byte_value,
    input  logic [47:0]           i_name_chars,
    input  logic [2:0]            i_name_length,
    input  logic [7:0]            i_sector_count,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [2:0]            o_out_status,
    output logic [7:0]            o_out_sector,
    output logic [7:0]            o_out_read_data,
    output logic                  o_out_last
);

    // memories
    logic [7:0] dir_mem [fdsa_pkg::DIR_BYTES];
    logic [7:0] map_mem [fdsa_pkg::MAP_ENTRIES];

    // request registers
    fdsa_pkg::t_action r_act;
    logic [9:0]  r_addr;
    logic [7:0]  r_byte;
    logic [47:0] r_name;
    logic [2:0]  r_len;
    logic [7:0]  r_count;
    logic [7:0]  r_fds;

    // counters and scratch
    logic [fdsa_pkg::DIR_AW-1:0] r_clr;
    logic [fdsa_pkg::E_W-1:0]    r_e;
    logic [fdsa_pkg::OFF_W-1:0]  r_i;
    logic [fdsa_pkg::SLOT_W-1:0] r_slot;
    logic [fdsa_pkg::GOT_W-1:0]  r_got;
    logic [7:0] r_picked [fdsa_pkg::SLOT_COUNT];
    logic [7:0] r_pend;
    logic [7:0] r_dir_q;
    logic [7:0] r_map_q;
    logic       r_rd_map;

    logic [7:0] r_out_sector;
    logic [7:0] r_out_data;
    logic [2:0] r_out_status;
    logic       r_out_last;
    logic       r_out_valid;

    logic                        in_map;
    logic                        in_dir;
    logic [fdsa_pkg::DIR_AW-1:0] dir_user;
    logic [fdsa_pkg::OFF_W-1:0]  off_sect;
    logic [7:0]                  name_byte;
    logic [7:0]                  rd_byte;
    logic [7:0]                  pick_byte;
    logic [fdsa_pkg::DIR_AW-1:0] dir_ra;
    logic [fdsa_pkg::MAP_AW-1:0] map_ra;
    logic                        ra_map;
    logic                        dir_we;
    logic [fdsa_pkg::DIR_AW-1:0] dir_wa;
    logic [7:0]                  dir_wd;
    logic                        map_we;
    logic [fdsa_pkg::MAP_AW-1:0] map_wa;
    logic [7:0]                  map_wd;
    logic [7:0]                  n_out_sector;

    // address decode of the user address
    assign in_map   = r_addr < 10'(fdsa_pkg::MAP_ENTRIES);
    assign in_dir   = (r_addr >= 10'(fdsa_pkg::DIR_BASE)) &&
                      (r_addr < 10'(fdsa_pkg::DIR_BASE + fdsa_pkg::DIR_BYTES));
    assign dir_user = fdsa_pkg::DIR_AW'(r_addr - 10'(fdsa_pkg::DIR_BASE));
    assign off_sect = r_i + fdsa_pkg::OFF_W'(fdsa_pkg::NAME_BYTES);
    assign name_byte = 8'(r_name >> {r_i, 3'b000});
    assign rd_byte   = r_rd_map ? r_map_q : r_dir_q;
    assign pick_byte = r_picked[r_i];

    // request capture and configuration
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act   <= fdsa_pkg::t_action'(i_action);
            r_addr  <= i_address;
            r_byte  <= i_byte_value;
            r_name  <= i_name_chars;
            r_len   <= (i_name_length > 3'(fdsa_pkg::NAME_BYTES)) ?
                       3'(fdsa_pkg::NAME_BYTES) : i_name_length;
            r_count <= i_sector_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fds <= 8'd3;
        end else if (i_cfg_we) begin
            r_fds <= i_cfg_data;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // scan counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.e_clr) begin
            r_e <= '0;
        end else if (i_cmd.e_inc) begin
            r_e <= r_e + 1'b1;
        end
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.slot_init) begin
            r_slot <= {1'b0, r_fds};
        end else if (i_cmd.slot_inc) begin
            r_slot <= r_slot + 1'b1;
        end
        if (i_cmd.got_clr) begin
            r_got <= '0;
        end else if (i_cmd.pick) begin
            r_got <= r_got + 1'b1;
        end
        if (i_cmd.pick) begin
            r_picked[r_got] <= r_slot[fdsa_pkg::MAP_AW-1:0];
        end
        if (i_cmd.pend_load) begin
            r_pend <= rd_byte;
        end
    end

    // read address select
    always_comb begin
        dir_ra = dir_user;
        map_ra = r_addr[fdsa_pkg::MAP_AW-1:0];
        ra_map = in_map;
        case (i_cmd.rd_sel)
            fdsa_pkg::RD_USER: begin
                dir_ra = dir_user;
                ra_map = in_map;
            end
            fdsa_pkg::RD_NAME: begin
                dir_ra = {r_e, r_i};
                ra_map = 1'b0;
            end
            fdsa_pkg::RD_SECT: begin
                dir_ra = {r_e, off_sect};
                ra_map = 1'b0;
            end
            fdsa_pkg::RD_HEAD: begin
                dir_ra = {r_e, {fdsa_pkg::OFF_W{1'b0}}};
                ra_map = 1'b0;
            end
            fdsa_pkg::RD_MAP: begin
                map_ra = r_slot[fdsa_pkg::MAP_AW-1:0];
                ra_map = 1'b1;
            end
            default: begin
                ra_map = 1'b0;
            end
        endcase
    end

    // write port select
    always_comb begin
        dir_we = 1'b0;
        dir_wa = r_clr;
        dir_wd = 8'h00;
        map_we = 1'b0;
        map_wa = r_clr[fdsa_pkg::MAP_AW-1:0];
        map_wd = 8'h00;
        if (i_cmd.clr_step) begin
            dir_we = 1'b1;
            map_we = 1'b1;
        end else if (i_cmd.wr_load) begin
            dir_we = in_dir;
            dir_wa = dir_user;
            dir_wd = r_byte;
            map_we = in_map;
            map_wa = r_addr[fdsa_pkg::MAP_AW-1:0];
            map_wd = r_byte;
        end else if (i_cmd.wr_name) begin
            dir_we = 1'b1;
            dir_wa = {r_e, r_i};
            dir_wd = ({2'b00, r_len} > r_i) ? name_byte : 8'h00;
        end else if (i_cmd.wr_commit) begin
            dir_we = 1'b1;
            dir_wa = {r_e, off_sect};
            dir_wd = pick_byte;
            map_we = 1'b1;
            map_wa = pick_byte;
            map_wd = fdsa_pkg::FREE_FULL;
        end
    end

    // directory memory
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_wa] <= dir_wd;
        end
        if (i_cmd.rd_en) begin
            r_dir_q <= dir_mem[dir_ra];
        end
    end

    // sector map memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (i_cmd.rd_en) begin
            r_map_q  <= map_mem[map_ra];
            r_rd_map <= ra_map;
        end
    end

    // result register
    always_comb begin
        case (i_cmd.out_sec)
            fdsa_pkg::SEC_PEND: n_out_sector = r_pend;
            fdsa_pkg::SEC_PICK: n_out_sector = pick_byte;
            default:            n_out_sector = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_sector <= n_out_sector;
            r_out_data   <= (i_cmd.out_status == fdsa_pkg::ST_READ && (in_map || in_dir)) ?
                            rd_byte : 8'h00;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_status    = r_out_status;
    assign o_out_sector    = r_out_sector;
    assign o_out_read_data = r_out_data;
    assign o_out_last      = r_out_last;

    // status to the controller
    always_comb begin
        o_sts.clr_done    = r_clr == fdsa_pkg::DIR_AW'(fdsa_pkg::DIR_BYTES - 1);
        o_sts.action      = r_act;
        o_sts.name_eq     = rd_byte == name_byte;
        o_sts.rd_zero     = rd_byte == 8'h00;
        o_sts.rd_ff       = rd_byte == fdsa_pkg::FREE_FULL;
        o_sts.i_at_len    = r_i == {2'b00, r_len};
        o_sts.i_sect_last = r_i == fdsa_pkg::OFF_W'(fdsa_pkg::SLOT_COUNT - 1);
        o_sts.i_name_last = r_i == fdsa_pkg::OFF_W'(fdsa_pkg::NAME_BYTES - 1);
        o_sts.i_got_last  = fdsa_pkg::GOT_W'(r_i + 1'b1) == r_got;
        o_sts.e_last      = r_e == fdsa_pkg::E_W'(fdsa_pkg::DIR_ENTRIES - 1);
        o_sts.slot_end    = r_slot >= fdsa_pkg::SLOT_W'(fdsa_pkg::MAP_ENTRIES);
        o_sts.got_eq      = {{(8-fdsa_pkg::GOT_W){1'b0}}, r_got} == r_count;
        o_sts.got_zero    = r_got == '0;
        o_sts.count_big   = r_count > 8'(fdsa_pkg::SLOT_COUNT);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

endmodule

/* rtl/core/fdsa_ctrl.sv */
// Controller state machine: clearing pass, load/read, lookup walk, create scan/commit.
// Depends on fdsa_pkg; drives fdsa_dpath through t_cmd.
module fdsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic [1:0]      i_req_action,
    output logic            o_req_ready,
    input  fdsa_pkg::t_sts  i_sts,
    output fdsa_pkg::t_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_RW_RD  = 16'h0004,
        S_RW_OUT = 16'h0008,
        S_LK_RD  = 16'h0010,
        S_LK_CHK = 16'h0020,
        S_LS_RD  = 16'h0040,
        S_LS_CHK = 16'h0080,
        S_LS_FIN = 16'h0100,
        S_CR_RD  = 16'h0200,
        S_CR_CHK = 16'h0400,
        S_SC_TST = 16'h0800,
        S_SC_CHK = 16'h1000,
        S_NM_WR  = 16'h2000,
        S_CM_WR  = 16'h4000,
        S_ONE    = 16'h8000
    } t_state;

    t_state            r_state, n_state;
    fdsa_pkg::t_status r_code, n_code;
    logic              r_pend, n_pend;
    logic              accept;

    assign o_req_ready = r_state == S_IDLE;
    assign accept      = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= fdsa_pkg::ST_SECTOR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_pend  <= n_pend;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_pend  = r_pend;
        o_cmd   = '0;
        o_cmd.capture = accept;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.e_clr = 1'b1;
                o_cmd.i_clr = 1'b1;
                n_pend      = 1'b0;
                if (accept) begin
                    unique case (fdsa_pkg::t_action'(i_req_action))
                        fdsa_pkg::ACT_LOOKUP: n_state = S_LK_RD;
                        fdsa_pkg::ACT_CREATE: n_state = S_CR_RD;
                        default:              n_state = S_RW_RD;
                    endcase
                end
            end
            // single byte load or read
            S_RW_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = fdsa_pkg::RD_USER;
                o_cmd.wr_load = i_sts.action == fdsa_pkg::ACT_LOAD;
                n_state       = S_RW_OUT;
            end
            S_RW_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = (i_sts.action == fdsa_pkg::ACT_LOAD) ?
                                       fdsa_pkg::ST_LOADED : fdsa_pkg::ST_READ;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            // lookup: compare name bytes of one entry
            S_LK_RD: begin
                if (i_sts.i_at_len) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = S_LS_RD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = fdsa_pkg::RD_NAME;
                    n_state      = S_LK_CHK;
                end
            end
            S_LK_CHK: begin
                if (i_sts.name_eq) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_LK_RD;
                end else if (i_sts.e_last) begin
                    n_code  = fdsa_pkg::ST_NOT_FOUND;
                    n_state = S_ONE;
                end else begin
                    o_cmd.e_inc = 1'b1;
                    o_cmd.i_clr = 1'b1;
                    n_state     = S_LK_RD;
                end
            end
            // lookup: list sectors, one held back to know the last
            S_LS_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fdsa_pkg::RD_SECT;
                n_state      = S_LS_CHK;
            end
            S_LS_CHK: begin
                if (i_sts.rd_zero) begin
                    if (r_pend) begin
                        n_state = S_LS_FIN;
                    end else begin
                        n_code  = fdsa_pkg::ST_EMPTY;
                        n_state = S_ONE;
                    end
                end else if (!r_pend || i_sts.out_free) begin
                    if (r_pend) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = fdsa_pkg::ST_SECTOR;
                        o_cmd.out_sec    = fdsa_pkg::SEC_PEND;
                    end
                    o_cmd.pend_load = 1'b1;
                    n_pend          = 1'b1;
                    if (i_sts.i_sect_last) begin
                        n_state = S_LS_FIN;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state     = S_LS_RD;
                    end
                end
            end
            S_LS_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = fdsa_pkg::ST_SECTOR;
                    o_cmd.out_sec    = fdsa_pkg::SEC_PEND;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            // create: find a free entry
            S_CR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = fdsa_pkg::RD_HEAD;
                n_state      = S_CR_CHK;
            end
            S_CR_CHK: begin
                if (i_sts.rd_zero) begin
                    if (i_sts.count_big) begin
                        n_code  = fdsa_pkg::ST_NO_SPACE;
                        n_state = S_ONE;
                    end else begin
                        o_cmd.slot_init = 1'b1;
                        o_cmd.got_clr   = 1'b1;
                        n_state         = S_SC_TST;
                    end
                end else if (i_sts.e_last) begin
                    n_code  = fdsa_pkg::ST_DIR_FULL;
                    n_state = S_ONE;
                end else begin
                    o_cmd.e_inc = 1'b1;
                    n_state     = S_CR_RD;
                end
            end
            // create: scan the map for free slots
            S_SC_TST: begin
                if (i_sts.got_eq) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = S_NM_WR;
                end else if (i_sts.slot_end) begin
                    n_code  = fdsa_pkg::ST_NO_SPACE;
                    n_state = S_ONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = fdsa_pkg::RD_MAP;
                    n_state      = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                o_cmd.pick     = !i_sts.rd_ff;
                o_cmd.slot_inc = 1'b1;
                n_state        = S_SC_TST;
            end
            // create: store the name, then commit sectors
            S_NM_WR: begin
                o_cmd.wr_name = 1'b1;
                if (i_sts.i_name_last) begin
                    o_cmd.i_clr = 1'b1;
                    if (i_sts.got_zero) begin
                        n_code  = fdsa_pkg::ST_EMPTY;
                        n_state = S_ONE;
                    end else begin
                        n_state = S_CM_WR;
                    end
                end else begin
                    o_cmd.i_inc = 1'b1;
                end
            end
            S_CM_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_commit  = 1'b1;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = fdsa_pkg::ST_SECTOR;
                    o_cmd.out_sec    = fdsa_pkg::SEC_PICK;
                    o_cmd.out_last   = i_sts.i_got_last;
                    if (i_sts.i_got_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                    end
                end
            end
            S_ONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_code;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/file_directory_sector_allocator.sv */
// Top level of the file directory sector allocator.
// Depends on fdsa_pkg, fdsa_ctrl, fdsa_dpath and the defines header.
//
// Channel   Dir  Handshake                 Payload
// s (req)   in   i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser
// m (res)   out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser, o_m_tlast
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data (first_data_sector)
//
// One request at a time; lookup and create walk the memories byte by byte.
// After reset a clearing pass zeroes both memories; no request is taken
// meanwhile. A stalled result holds the controller at its emit step.
module file_directory_sector_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [9:0] address, [17:10] byte_value, [65:18] name_chars,
    // [68:66] name_length, [76:69] sector_count, [79:77] zero
    input  logic [79:0] i_s_tdata,
    // [1:0] action
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] sector, [15:8] read_data
    output logic [15:0] o_m_tdata,
    // [2:0] status
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    fdsa_pkg::t_cmd cmd;
    fdsa_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    fdsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .i_req_action (i_s_tuser),
        .o_req_ready  (o_s_tready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    fdsa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_s_tuser),
        .i_address       (i_s_tdata[9:0]),
        .i_byte_value    (i_s_tdata[17:10]),
        .i_name_chars    (i_s_tdata[65:18]),
        .i_name_length   (i_s_tdata[68:66]),
        .i_sector_count  (i_s_tdata[76:69]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_out_status    (o_m_tuser),
        .o_out_sector    (o_m_tdata[7:0]),
        .o_out_read_data (o_m_tdata[15:8]),
        .o_out_last      (o_m_tlast)
    );

`include "file_directory_sector_allocator_defines.svh"

    // read data only on read results
    `FDSA_IMPLY(a_data_only_read, o_m_tvalid && o_m_tuser != fdsa_pkg::ST_READ, o_m_tdata[15:8] == 8'h00, "read_data set on non-read result")
    // non-sector results are single and carry no sector
    `FDSA_IMPLY(a_status_single, o_m_tvalid && o_m_tuser != fdsa_pkg::ST_SECTOR, o_m_tlast && o_m_tdata[7:0] == 8'h00, "bad non-sector result")
    // one request in flight
    `FDSA_NEXT(a_one_req, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while busy")

endmodule
